[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the grow light timer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/glpt_pkg.sv]
// ----------------------------------------------------------------------------
// glpt_pkg
// Types and constants of the grow light PWM and pump timer.
// ----------------------------------------------------------------------------
`default_nettype none

package glpt_pkg;

    localparam int NUM_CHANNELS    = 6;
    localparam int PWM_PERIOD      = 10;
    localparam int DAY_TICKS       = 86400000;
    localparam int SECOND_TICKS    = 1000;
    localparam int HEARTBEAT_TICKS = 2000;

    localparam int TIME_W  = 27;
    localparam int CHAN_W  = 3;
    localparam int DUTY_W  = 4;
    localparam int PUMP_W  = 16;
    localparam int OUT_W   = 6;
    localparam int PHASE_W = $clog2(PWM_PERIOD);
    localparam int SEC_W   = $clog2(SECOND_TICKS);
    localparam int HB_W    = $clog2(HEARTBEAT_TICKS);

    localparam logic [TIME_W-1:0]  DAY_LAST   = TIME_W'(DAY_TICKS - 1);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PWM_PERIOD - 1);
    localparam logic [SEC_W-1:0]   SEC_LAST   = SEC_W'(SECOND_TICKS - 1);
    localparam logic [HB_W-1:0]    HB_LAST    = HB_W'(HEARTBEAT_TICKS - 1);

    typedef enum logic [0:0] {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [CHAN_W-1:0]  channel;
        logic               enable;
        logic               auto_mode;
        logic [DUTY_W-1:0]  manual_duty;
        logic [DUTY_W-1:0]  auto_duty;
        logic [TIME_W-1:0]  auto_end_time;
        logic               sunlight;
        logic [PUMP_W-1:0]  pump_seconds;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0]   light_levels;
        logic [OUT_W-1:0]   pump_stop;
        logic               heartbeat;
        logic [TIME_W-1:0]  time_of_day;
    } result_t;

endpackage

`default_nettype wire

[sv/grow_light_pwm_and_pump_timer.sv]
// ----------------------------------------------------------------------------
// grow_light_pwm_and_pump_timer
// Six-channel light PWM and pump countdown timer on a day-wrapping tick count.
// ----------------------------------------------------------------------------
// Input channel item/item_valid/item_ready carries one word: either a
// millisecond tick or a write of one channel's settings. Output channel
// result/result_valid/result_ready returns exactly one word per input word,
// in order: light levels, pump stop pulses, heartbeat and time of day.
// An accepted word is held in an input register and is processed when the
// output register is empty or is being drained; its result is then loaded
// into the output register. One word is taken per cycle for as long as the
// output is drained; all channels are updated together by the per-channel
// logic between the two registers.
// The PWM phase, the second count and the heartbeat count run as separate
// counters beside the time of day, so no division is needed.
// Reset clears the counters and settings, with every channel enabled.
// When the receiver stalls, the result waits in the output register and the
// input register still takes one more word before item_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module grow_light_pwm_and_pump_timer
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire glpt_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output glpt_pkg::result_t      result
);

    import glpt_pkg::*;

    logic                       in_valid_reg;
    item_t                      in_word_reg;
    logic                       result_valid_reg;
    result_t                    result_reg;
    logic                       advance;

    logic [TIME_W-1:0]          tick_count_reg, tick_count_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [SEC_W-1:0]           sec_reg, sec_next;
    logic [HB_W-1:0]            hb_reg, hb_next;

    logic [NUM_CHANNELS-1:0]    enable_reg, enable_next;
    logic [NUM_CHANNELS-1:0]    auto_reg, auto_next;
    logic [NUM_CHANNELS-1:0]    sunlight_reg, sunlight_next;
    logic [NUM_CHANNELS-1:0]    turned_off_reg, turned_off_next;
    logic [NUM_CHANNELS-1:0]    light_reg, light_next;
    logic [DUTY_W-1:0]          manual_duty_reg [NUM_CHANNELS];
    logic [DUTY_W-1:0]          manual_duty_next [NUM_CHANNELS];
    logic [DUTY_W-1:0]          auto_duty_reg [NUM_CHANNELS];
    logic [DUTY_W-1:0]          auto_duty_next [NUM_CHANNELS];
    logic [TIME_W-1:0]          end_time_reg [NUM_CHANNELS];
    logic [TIME_W-1:0]          end_time_next [NUM_CHANNELS];
    logic [PUMP_W-1:0]          countdown_reg [NUM_CHANNELS];
    logic [PUMP_W-1:0]          countdown_next [NUM_CHANNELS];
    logic [DUTY_W-1:0]          auto_target [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]    stop_next;
    result_t                    result_next;

    assign advance      = in_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            auto_target[k] = sunlight_reg[k] ? (auto_duty_reg[k] >> 1) : auto_duty_reg[k];
        end
    end

    always_comb
    begin
        tick_count_next  = tick_count_reg;
        phase_next       = phase_reg;
        sec_next         = sec_reg;
        hb_next          = hb_reg;
        enable_next      = enable_reg;
        auto_next        = auto_reg;
        sunlight_next    = sunlight_reg;
        turned_off_next  = turned_off_reg;
        light_next       = light_reg;
        manual_duty_next = manual_duty_reg;
        auto_duty_next   = auto_duty_reg;
        end_time_next    = end_time_reg;
        countdown_next   = countdown_reg;
        stop_next        = '0;

        if (in_word_reg.operation == OP_WRITE)
        begin
            // Only channels that exist can match, so other channel codes are ignored.
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                if (in_word_reg.channel == CHAN_W'(k))
                begin
                    enable_next[k]      = in_word_reg.enable;
                    auto_next[k]        = in_word_reg.auto_mode;
                    manual_duty_next[k] = in_word_reg.manual_duty;
                    auto_duty_next[k]   = in_word_reg.auto_duty;
                    end_time_next[k]    = in_word_reg.auto_end_time;
                    sunlight_next[k]    = in_word_reg.sunlight;
                    countdown_next[k]   = in_word_reg.pump_seconds;
                end
            end
        end
        else
        begin
            if (tick_count_reg >= DAY_LAST)
            begin
                tick_count_next = '0;
                phase_next      = '0;
                sec_next        = '0;
                hb_next         = '0;
            end
            else
            begin
                tick_count_next = tick_count_reg + 1'b1;
                phase_next      = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
                sec_next        = (sec_reg == SEC_LAST) ? '0 : sec_reg + 1'b1;
                hb_next         = (hb_reg == HB_LAST) ? '0 : hb_reg + 1'b1;
            end

            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                if (enable_reg[k])
                begin
                    if (!auto_reg[k])
                    begin
                        if (manual_duty_reg[k] != '0)
                        begin
                            if (phase_next == '0)
                            begin
                                light_next[k] = 1'b1;
                            end
                            if (phase_next == manual_duty_reg[k])
                            begin
                                light_next[k] = 1'b0;
                            end
                        end
                    end
                    else if (auto_duty_reg[k] != '0 && end_time_reg[k] > tick_count_next)
                    begin
                        if (phase_next == '0)
                        begin
                            light_next[k]      = 1'b1;
                            turned_off_next[k] = 1'b0;
                        end
                        if (phase_next == auto_target[k])
                        begin
                            light_next[k] = 1'b0;
                        end
                    end
                    else if (end_time_reg[k] < tick_count_next && !turned_off_reg[k])
                    begin
                        turned_off_next[k] = 1'b1;
                        light_next[k]      = 1'b0;
                    end
                end
            end

            if (tick_count_next != '0 && sec_next == '0)
            begin
                for (int k = 0; k < NUM_CHANNELS; k++)
                begin
                    if (countdown_reg[k] != '0)
                    begin
                        countdown_next[k] = countdown_reg[k] - 1'b1;
                        stop_next[k]      = (countdown_reg[k] == PUMP_W'(1));
                    end
                end
            end
        end

        result_next.light_levels = OUT_W'(light_next);
        result_next.pump_stop    = OUT_W'(stop_next);
        result_next.heartbeat    = (hb_next != '0);
        result_next.time_of_day  = tick_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            tick_count_reg   <= '0;
            phase_reg        <= '0;
            sec_reg          <= '0;
            hb_reg           <= '0;
            enable_reg       <= '1;
            auto_reg         <= '0;
            sunlight_reg     <= '0;
            turned_off_reg   <= '0;
            light_reg        <= '0;
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                manual_duty_reg[k] <= '0;
                auto_duty_reg[k]   <= '0;
                end_time_reg[k]    <= '0;
                countdown_reg[k]   <= '0;
            end
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                tick_count_reg   <= tick_count_next;
                phase_reg        <= phase_next;
                sec_reg          <= sec_next;
                hb_reg           <= hb_next;
                enable_reg       <= enable_next;
                auto_reg         <= auto_next;
                sunlight_reg     <= sunlight_next;
                turned_off_reg   <= turned_off_next;
                light_reg        <= light_next;
                manual_duty_reg  <= manual_duty_next;
                auto_duty_reg    <= auto_duty_next;
                end_time_reg     <= end_time_next;
                countdown_reg    <= countdown_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_word_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    `ASSERT_IMPLY(a_tick_in_day, clk, rst_n, 1'b1, tick_count_reg <= DAY_LAST)
    `ASSERT_IMPLY(a_phase_in_period, clk, rst_n, 1'b1, phase_reg <= PHASE_LAST)
    `ASSERT_NEXT(a_write_holds_time, clk, rst_n,
        advance && in_word_reg.operation == OP_WRITE, $stable(tick_count_reg))
    `ASSERT_NEXT(a_stop_on_second, clk, rst_n, advance && stop_next != '0, sec_reg == '0)
    `ASSERT_IMPLY(a_stall_means_full, clk, rst_n, !item_ready, in_valid_reg && result_valid_reg)

endmodule

`default_nettype wire
